[src/pmrs_pkg.sv]
// ----------------------------------------------------------------------------
// pmrs_pkg: shared constants for the prefetch miss-run splitter
// Field widths, stream packing widths and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package pmrs_pkg;

   localparam int LINE_INDEX_BITS = 40;
   localparam int COUNT_BITS      = 16;

   // req tdata: range_first, range_count, hit; rsp tdata: run_first, run_count
   localparam int IN_USED_BITS  = LINE_INDEX_BITS + COUNT_BITS + 1;
   localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;
   localparam int OUT_USED_BITS = LINE_INDEX_BITS + COUNT_BITS;
   localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

   localparam int CSR_DATA_BITS  = LINE_INDEX_BITS;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME_LINES    = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_TOTAL_LINES = CSR_INDEX_BITS'(1);

   localparam logic [COUNT_BITS-1:0] MAX_TOTAL_RESET = COUNT_BITS'(64);

   typedef logic [LINE_INDEX_BITS-1:0] line_type;
   typedef logic [COUNT_BITS-1:0]      count_type;

endpackage

`default_nettype wire

[src/prefetch_miss_run_splitter.sv]
// ----------------------------------------------------------------------------
// prefetch_miss_run_splitter: split a prefetch range into runs of missed lines
//
// The req stream carries one cache line per transfer. A transfer with tuser
// high opens a new range (first line, line count) and also carries the hit
// bit of that first line; following transfers carry one hit bit per line.
// The range is clipped to the volume length and ignored if it starts at or
// past the volume end. Consecutive misses are grouped into runs, cut at the
// per-run limit; each run leaves on the rsp stream as first line and length,
// with tlast set when the run used up the total budget (the range then ends).
// Configuration: csr_write/csr_index/csr_wdata; the user writes these only
// while idle, the block does not enforce it. One line per cycle unless rsp
// stalls; a run is on rsp in the cycle after its closing transfer. The result
// register decouples the two sides: req_tready stays high while rsp is empty
// or being taken, so a stalled receiver holds at most one run and stalls req.
// Reset (synchronous, active high) closes any open range, empties the
// result register and restores volume_lines = 0, max_total_lines = 64.
// ----------------------------------------------------------------------------
`default_nettype none

module prefetch_miss_run_splitter
   import pmrs_pkg::*;
(
   input  wire                      clock,
   input  wire                      reset,
   // configuration write port
   input  wire                      csr_write,
   input  wire [CSR_INDEX_BITS-1:0] csr_index,
   input  wire [CSR_DATA_BITS-1:0]  csr_wdata,
   // line stream
   input  wire                      req_tvalid,
   output logic                     req_tready,
   // tdata from bit 0: range_first, range_count, hit, zero padding
   input  wire [IN_DATA_BITS-1:0]   req_tdata,
   // tuser: new_range
   input  wire                      req_tuser,
   // run stream
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   // tdata from bit 0: run_first, run_count, zero padding
   output logic [OUT_DATA_BITS-1:0] rsp_tdata,
   // tlast: budget_spent
   output logic                     rsp_tlast
);

   // configuration
   line_type  volume_ff;
   count_type max_total_ff;

   // range state
   line_type  line_pos_ff, line_pos_in;
   line_type  range_end_ff, range_end_in;
   line_type  run_start_ff, run_start_in;
   count_type run_len_ff, run_len_in;
   count_type total_ff, total_in;
   count_type run_limit_ff, run_limit_in;
   logic      active_ff, active_in;

   // result register
   logic      rsp_valid_ff;
   line_type  rsp_first_ff;
   count_type rsp_count_ff;
   logic      rsp_spent_ff;

   // input fields
   line_type  in_first;
   count_type in_count;
   logic      in_hit;
   logic      req_accept;

   // step logic
   line_type  avail;
   logic      clip;
   count_type clip_count;
   logic      open_range;
   line_type  pos_ld, end_ld, start_ld;
   count_type len_ld, total_ld, limit_ld;
   logic      act_ld;
   count_type eff_limit;
   line_type  start_step;
   count_type len_step;
   logic      emit_run_hit;
   logic      emit_run_full;
   line_type  pos_next;
   logic      end_hit;
   logic      emit;
   count_type total_emit;
   logic      spent;
   count_type left;

   assign in_first = req_tdata[LINE_INDEX_BITS-1:0];
   assign in_count = req_tdata[LINE_INDEX_BITS +: COUNT_BITS];
   assign in_hit   = req_tdata[LINE_INDEX_BITS + COUNT_BITS];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      // load a new range, or carry the open one
      avail      = volume_ff - in_first;
      clip       = LINE_INDEX_BITS'(in_count) > avail;
      clip_count = clip ? avail[COUNT_BITS-1:0] : in_count;
      open_range = (in_first < volume_ff) && (clip_count != '0);

      pos_ld   = line_pos_ff;
      end_ld   = range_end_ff;
      start_ld = run_start_ff;
      len_ld   = run_len_ff;
      total_ld = total_ff;
      limit_ld = run_limit_ff;
      act_ld   = active_ff;
      if (req_tuser) begin
         act_ld   = 1'b0;
         len_ld   = '0;
         total_ld = '0;
         if (open_range) begin
            pos_ld   = in_first;
            end_ld   = clip ? volume_ff : in_first + LINE_INDEX_BITS'(in_count);
            start_ld = in_first;
            limit_ld = (clip_count < max_total_ff) ? clip_count : max_total_ff;
            act_ld   = 1'b1;
         end
      end

      // a zero limit still lets one line through
      eff_limit = (limit_ld == '0) ? COUNT_BITS'(1) : limit_ld;

      start_step    = start_ld;
      len_step      = len_ld;
      emit_run_hit  = 1'b0;
      emit_run_full = 1'b0;
      if (act_ld) begin
         if (in_hit) begin
            emit_run_hit = (len_ld != '0);
         end else begin
            if (len_ld == '0) begin
               start_step = pos_ld;
            end
            len_step      = len_ld + COUNT_BITS'(1);
            emit_run_full = (len_step >= eff_limit);
         end
      end

      pos_next = act_ld ? pos_ld + LINE_INDEX_BITS'(1) : pos_ld;
      end_hit  = act_ld && (pos_next == end_ld);
      emit     = emit_run_hit || emit_run_full || (end_hit && (len_step != '0));

      total_emit = total_ld + len_step;
      spent      = (total_emit >= max_total_ff);
      left       = max_total_ff - total_emit;

      line_pos_in  = pos_next;
      range_end_in = end_ld;
      run_start_in = start_step;
      run_len_in   = (emit || end_hit) ? '0 : len_step;
      total_in     = emit ? total_emit : total_ld;
      run_limit_in = limit_ld;
      if (emit && !spent && (left < limit_ld)) begin
         run_limit_in = left;
      end
      active_in = act_ld && !(emit && spent) && !end_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff    <= '0;
         max_total_ff <= MAX_TOTAL_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_VOLUME_LINES:    volume_ff    <= csr_wdata[LINE_INDEX_BITS-1:0];
            CSR_MAX_TOTAL_LINES: max_total_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_pos_ff  <= '0;
         range_end_ff <= '0;
         run_start_ff <= '0;
         run_len_ff   <= '0;
         total_ff     <= '0;
         run_limit_ff <= '0;
         active_ff    <= 1'b0;
      end else if (req_accept) begin
         line_pos_ff  <= line_pos_in;
         range_end_ff <= range_end_in;
         run_start_ff <= run_start_in;
         run_len_ff   <= run_len_in;
         total_ff     <= total_in;
         run_limit_ff <= run_limit_in;
         active_ff    <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= emit;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: load only with a fresh run
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         rsp_first_ff <= start_step;
         rsp_count_ff <= len_step;
         rsp_spent_ff <= spent;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_DATA_BITS'({rsp_count_ff, rsp_first_ff});
   assign rsp_tlast  = rsp_spent_ff;

`ifndef SYNTHESIS
   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff != '0))
      else $error("emitted run has zero length");

   a_idle_no_run: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> (run_len_ff == '0))
      else $error("open run without an open range");

   a_run_below_limit: assert property (@(posedge clock) disable iff (reset)
      (active_ff && (run_limit_ff != '0)) |-> (run_len_ff < run_limit_ff))
      else $error("open run reached its limit without being emitted");

   a_spent_closes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && emit && spent) |=> !active_ff)
      else $error("range still open after budget was spent");
`endif

endmodule

`default_nettype wire

[sim/prefetch_miss_run_splitter_tb.sv]
// ----------------------------------------------------------------------------
// prefetch_miss_run_splitter_tb: self-checking bench for the miss-run splitter
// Feeds prefetch ranges and per-line hit bits on the req stream. A line-level
// predictor computes each expected miss run. Runs on the rsp stream are
// compared field by field in order. Sender gaps, receiver stalls and several
// volume/budget settings are applied in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module prefetch_miss_run_splitter_tb;
   import pmrs_pkg::*;

   localparam int       HIT_BIT         = LINE_INDEX_BITS + COUNT_BITS;
   localparam int       SETTLE_CYCLES   = 4;
   localparam int       WATCHDOG_LIMIT  = 4000;
   localparam line_type LINE_MAX        = '1;

   typedef struct packed {
      line_type  first;
      count_type count;
      logic      spent;
   } run_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     csr_write  = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_VOLUME_LINES;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [IN_DATA_BITS-1:0]  req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [OUT_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int rsp_hold_cycles = 0;
   int mismatches      = 0;
   int quiet_cycles    = 0;

   run_type pending_runs[$];

   // predictor copy of the registers and of the range state
   line_type  cfg_volume   = '0;
   count_type cfg_budget   = MAX_TOTAL_RESET;
   line_type  cur_line     = '0;
   line_type  range_stop   = '0;
   line_type  open_start   = '0;
   count_type open_len     = '0;
   count_type lines_sent   = '0;
   count_type per_run_cap  = '0;
   logic      range_open   = 1'b0;

   prefetch_miss_run_splitter u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic run_type close_run();
      run_type   r;
      count_type left;
      r.first    = open_start;
      r.count    = open_len;
      lines_sent = lines_sent + open_len;
      open_len   = '0;
      r.spent    = (lines_sent >= cfg_budget);
      if (r.spent) begin
         range_open = 1'b0;
      end else begin
         left = cfg_budget - lines_sent;
         if (left < per_run_cap) per_run_cap = left;
      end
      return r;
   endfunction

   // one line in, at most one run out
   function automatic logic split_line(input logic opens, input line_type first,
                                       input count_type count, input logic hit,
                                       output run_type r);
      logic      emitted;
      count_type cap;
      line_type  span;
      emitted = 1'b0;
      r       = '0;
      if (opens) begin
         range_open = 1'b0;
         open_len   = '0;
         lines_sent = '0;
         if (first >= cfg_volume) return 1'b0;
         span = cfg_volume - first;
         if (line_type'(count) > span) count = count_type'(span);
         if (count == '0) return 1'b0;
         cur_line    = first;
         range_stop  = first + line_type'(count);
         open_start  = first;
         per_run_cap = (count < cfg_budget) ? count : cfg_budget;
         range_open  = 1'b1;
      end
      if (!range_open) return 1'b0;
      cap = (per_run_cap == '0) ? count_type'(1) : per_run_cap;
      if (hit) begin
         if (open_len != '0) begin
            r       = close_run();
            emitted = 1'b1;
         end
      end else begin
         if (open_len == '0) open_start = cur_line;
         open_len = open_len + 1'b1;
         if (open_len >= cap) begin
            r       = close_run();
            emitted = 1'b1;
         end
      end
      cur_line = cur_line + 1'b1;
      // last line of the range flushes an open run
      if (range_open && cur_line == range_stop) begin
         if (open_len != '0 && !emitted) begin
            r       = close_run();
            emitted = 1'b1;
         end
         range_open = 1'b0;
         open_len   = '0;
      end
      return emitted;
   endfunction

   function automatic logic [63:0] random_hits(input int pct);
      logic [63:0] hits;
      for (int i = 0; i < 64; i++) hits[i] = ($urandom_range(99) < pct);
      return hits;
   endfunction

   // predict on each line transfer, check each run transfer, watch for hangs
   always @(posedge clock) begin : scoreboard
      run_type predicted;
      run_type observed;
      logic    moved;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         moved = csr_write;
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            if (split_line(req_tuser, req_tdata[LINE_INDEX_BITS-1:0],
                           req_tdata[LINE_INDEX_BITS +: COUNT_BITS],
                           req_tdata[HIT_BIT], predicted))
               pending_runs.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            moved          = 1'b1;
            observed.first = rsp_tdata[LINE_INDEX_BITS-1:0];
            observed.count = rsp_tdata[LINE_INDEX_BITS +: COUNT_BITS];
            observed.spent = rsp_tlast;
            if (pending_runs.size() == 0) begin
               $error("unexpected run: run_first %h run_count %0d budget_spent %0b",
                      observed.first, observed.count, observed.spent);
               mismatches++;
            end else begin
               predicted = pending_runs.pop_front();
               if (observed.first !== predicted.first) begin
                  $error("run_first: expected %h, actual %h",
                         predicted.first, observed.first);
                  mismatches++;
               end
               if (observed.count !== predicted.count) begin
                  $error("run_count: expected %0d, actual %0d",
                         predicted.count, observed.count);
                  mismatches++;
               end
               if (observed.spent !== predicted.spent) begin
                  $error("budget_spent: expected %0b, actual %0b",
                         predicted.spent, observed.spent);
                  mismatches++;
               end
            end
         end
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver: long hold when asked, random stalls otherwise
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready = 1'b0;
         rsp_hold_cycles--;
      end else begin
         rsp_tready = ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_line(input logic opens, input line_type first,
                            input count_type count, input logic hit);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = opens;
      req_tdata  = '0;
      // range fields are don't-care on hit-only lines: fill with noise
      req_tdata[LINE_INDEX_BITS-1:0] = opens ? first : line_type'({$urandom, $urandom});
      req_tdata[LINE_INDEX_BITS +: COUNT_BITS] = opens ? count : count_type'($urandom);
      req_tdata[HIT_BIT] = hit;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_lines(input logic opens, input line_type first, input count_type count,
                             input int n, input logic [63:0] hits);
      for (int i = 0; i < n; i++) send_line(opens && i == 0, first, count, hits[i]);
   endtask

   task automatic wait_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input line_type volume, input count_type budget);
      wait_results();
      @(negedge clock);
      csr_write  = 1'b1;
      csr_index  = CSR_VOLUME_LINES;
      csr_wdata  = volume;
      cfg_volume = volume;
      @(negedge clock);
      csr_index  = CSR_MAX_TOTAL_LINES;
      csr_wdata  = CSR_DATA_BITS'(budget);
      cfg_budget = budget;
      @(negedge clock);
      csr_write  = 1'b0;
   endtask

   task automatic test_empty_volume();
      configure('0, MAX_TOTAL_RESET);
      send_line(1'b1, '0, 16'd5, 1'b0);
   endtask

   task automatic test_directed_ranges();
      configure(40'd1000, MAX_TOTAL_RESET);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // miss miss hit miss hit hit
      send_lines(1'b1, 40'd10, 16'd6, 6, 64'b110100);
      // clipped at the volume end
      send_lines(1'b1, 40'd998, 16'd10, 2, '0);
      // empty range, then a hit bit with nothing open
      send_line(1'b1, 40'd500, '0, 1'b0);
      send_line(1'b0, '0, '0, 1'b1);
      // abandon an open run with a new range
      send_lines(1'b1, 40'd100, 16'd8, 3, '0);
      send_lines(1'b1, 40'd200, 16'd1, 1, '0);
   endtask

   task automatic test_budget_limits();
      configure(LINE_MAX, 16'd5);
      send_lines(1'b1, LINE_MAX - 1'b1, 16'hFFFF, 1, '0);
      send_line(1'b1, LINE_MAX, 16'hFFFF, 1'b0);
      // run of 2, then the limit shrinks to the 3 left
      send_lines(1'b1, '0, 16'd10, 6, 64'h4);
      // all misses: cut at the budget
      send_lines(1'b1, 40'd20, 16'd7, 5, '0);
   endtask

   task automatic test_zero_budget();
      configure(40'd1000, '0);
      send_lines(1'b1, 40'd50, 16'd4, 2, 64'h1);
   endtask

   task automatic test_backpressure();
      configure(40'd1000, 16'd2);
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      rsp_hold_cycles = 200;
      for (int k = 0; k < 15; k++) send_lines(1'b1, line_type'(k * 4), 16'd2, 2, '0);
   endtask

   task automatic test_sender_pause();
      configure(40'd1000, MAX_TOTAL_RESET);
      send_idle_pct  = 54;
      recv_stall_pct = 54;
      send_lines(1'b1, 40'd300, 16'd30, 12, random_hits(40));
      // hold the sender mid-range until every run is out
      wait_results();
      send_lines(1'b0, '0, '0, 18, random_hits(40));
   endtask

   task automatic test_random_ranges(input int n_items, input int send_pct, input int recv_pct,
                                     input line_type volume, input count_type budget);
      int        done;
      int        kind;
      int        n;
      line_type  first;
      line_type  span;
      count_type count;
      configure(volume, budget);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      done = 0;
      while (done < n_items) begin
         kind = $urandom_range(99);
         if (volume <= 40 || $urandom_range(1))
            first = line_type'({$urandom, $urandom} % volume);
         else
            first = volume - line_type'($urandom_range(1, 40));
         span = volume - first;
         if (kind < 75) begin
            count = ($urandom_range(9) == 0) ? count_type'($urandom_range(25, 64))
                                             : count_type'($urandom_range(1, 12));
            n = (line_type'(count) > span) ? int'(span) : int'(count);
            send_lines(1'b1, first, count, n, random_hits($urandom_range(90)));
            done += n;
         end else if (kind < 87) begin
            // broken range: cut short, left open for the next one to abandon
            n = $urandom_range(1, 12);
            send_lines(1'b1, first, count_type'($urandom), n, random_hits($urandom_range(90)));
            done += n;
         end else if (kind < 94) begin
            send_lines(1'b0, '0, '0, $urandom_range(1, 3), random_hits(50));
         end else if ($urandom_range(1)) begin
            send_line(1'b1, volume | line_type'($urandom), count_type'($urandom),
                      1'($urandom_range(1)));
         end else begin
            send_line(1'b1, first, '0, 1'($urandom_range(1)));
         end
      end
      // close whatever is still open before the next setting
      send_line(1'b1, volume, '0, 1'b0);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_volume();
      test_directed_ranges();
      test_budget_limits();
      test_zero_budget();
      test_backpressure();
      test_sender_pause();
      test_random_ranges(140, 0, 0, LINE_MAX, 16'hFFFF);
      test_random_ranges(140, 54, 0, 40'd1000, 16'd10);
      test_random_ranges(140, 0, 54, 40'd60, 16'd1);
      test_random_ranges(140, 12, 12,
                         {8'($urandom_range(255)), 32'($urandom)} | 40'd64,
                         count_type'($urandom_range(2, 40)));

      wait_results();
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
